// File: rtl/core/swmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmh_pkg: shared types and constants
// Constants, sequencer types and one helper for the sliding window minimum.
// ----------------------------------------------------------------------------
package swmh_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int POS_W        = $clog2(MAX_WINDOW);
    localparam int CFG_W        = 7;
    localparam int CNT_W        = POS_W + 1;
    localparam int DATA_BYTES   = (SAMPLE_WIDTH + 7) / 8;
    localparam int TDATA_W      = DATA_BYTES * 8;
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(16);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_REPL_RD,
        ST_REPL_WR,
        ST_SD_START,
        ST_SD_RD_L,
        ST_SD_RD_R,
        ST_SD_CMP,
        ST_SD_SW1,
        ST_SD_SW2,
        ST_SD_SW3,
        ST_SD_DONE,
        ST_ROOT_RD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MODE_BUILD,
        MODE_DOWN,
        MODE_UP
    } mode_t;

    // Compare signed samples: a > b.
    function automatic logic greater(input logic [SAMPLE_WIDTH-1:0] a,
                                     input logic [SAMPLE_WIDTH-1:0] b);
        greater = $signed(a) > $signed(b);
    endfunction

endpackage

// File: rtl/core/sliding_window_minimum_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum_heap: minimum of the last window_size samples
// Indexed binary min-heap in RAM, walked by one compare/swap sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one signed 32-bit sample per item. m_axis_* returns the
//   window minimum once the window is full; a filling item gives no result.
//   window_size is written through cfg_we/cfg_wdata while idle; each write
//   restarts the window empty (0 acts as 1, above 64 saturates to 64).
// Timing:
//   s_axis_tready is low while an item is processed. A sift runs its start,
//   read of both children, compare and finish, plus two swap writes and a
//   re-read for each level it swaps. A replacement that sifts down does so
//   from the replaced position (heap depth 6 for a window of 64); one that
//   goes up sifts every ancestor in turn. The build when the window fills
//   sifts window/2 roots.
//   The result waits in an output register; while m_axis_tready is low the
//   block holds it and takes no new item.
// Reset:
//   aresetn low empties the window and sets window_size to 16.
// ----------------------------------------------------------------------------
module sliding_window_minimum_heap (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [swmh_pkg::CFG_W-1:0]        cfg_wdata,   // window_size
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [swmh_pkg::TDATA_W-1:0]      s_axis_tdata, // [31:0] sample
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [swmh_pkg::TDATA_W-1:0]      m_axis_tdata  // [31:0] window_min
);

    localparam int PW = swmh_pkg::POS_W;
    localparam int CW = swmh_pkg::CNT_W;
    localparam int SW = swmh_pkg::SAMPLE_WIDTH;

    swmh_pkg::state_t state_reg, state_next;
    swmh_pkg::mode_t  mode_reg, mode_next;

    logic [swmh_pkg::CFG_W-1:0] wsize_reg;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] fill_reg, fill_next;
    logic [PW-1:0] oldest_reg, oldest_next;
    logic [SW-1:0] key_reg, key_next;
    logic [PW-1:0] pos_reg, pos_next;    // sift position
    logic [CW-1:0] root_reg, root_next;  // build / upward walk
    logic [SW-1:0] pv_reg, pv_next, lv_reg, lv_next;
    logic [PW-1:0] ps_reg, ps_next, ls_reg, ls_next;
    logic [PW-1:0] m_reg, m_next;        // chosen child position
    logic [SW-1:0] mv_reg, mv_next;
    logic [PW-1:0] ms_reg, ms_next;
    logic          up_reg, up_next;
    logic [SW-1:0] out_reg;
    logic          out_valid_reg;

    // RAM ports
    logic          hv_we, hs_we, sp_we;
    logic [PW-1:0] hv_addr, hs_addr, sp_addr;
    logic [SW-1:0] hv_wdata, hv_rdata;
    logic [PW-1:0] hs_wdata, hs_rdata, sp_wdata, sp_rdata;

    swmh_ram #(.WIDTH(SW), .DEPTH(swmh_pkg::MAX_WINDOW)) u_heap_value (
        .aclk(aclk), .we(hv_we), .addr(hv_addr), .wdata(hv_wdata), .rdata(hv_rdata));
    swmh_ram #(.WIDTH(PW), .DEPTH(swmh_pkg::MAX_WINDOW)) u_heap_slot (
        .aclk(aclk), .we(hs_we), .addr(hs_addr), .wdata(hs_wdata), .rdata(hs_rdata));
    swmh_ram #(.WIDTH(PW), .DEPTH(swmh_pkg::MAX_WINDOW)) u_slot_pos (
        .aclk(aclk), .we(sp_we), .addr(sp_addr), .wdata(sp_wdata), .rdata(sp_rdata));

    always_comb begin
        if (wsize_reg == '0) begin
            n_eff = CW'(1);
        end else if ({1'b0, wsize_reg} > (swmh_pkg::CFG_W + 1)'(swmh_pkg::MAX_WINDOW)) begin
            n_eff = CW'(swmh_pkg::MAX_WINDOW);
        end else begin
            n_eff = CW'(wsize_reg);
        end
    end

    logic [CW:0] lpos, rpos;
    logic        l_ok, r_ok;
    assign lpos = (CW + 1)'({pos_reg, 1'b1});
    assign rpos = lpos + (CW + 1)'(1);
    assign l_ok = lpos < {1'b0, n_eff};
    assign r_ok = rpos < {1'b0, n_eff};

    assign s_axis_tready = (state_reg == swmh_pkg::ST_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = swmh_pkg::TDATA_W'(out_reg);

    // Next state
    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        root_next   = root_reg;
        pv_next = pv_reg; lv_next = lv_reg;
        ps_next = ps_reg; ls_next = ls_reg;
        m_next = m_reg; mv_next = mv_reg; ms_next = ms_reg;
        up_next = up_reg;
        unique case (state_reg)
            swmh_pkg::ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    key_next = s_axis_tdata[SW-1:0];
                    if (fill_reg < n_eff) begin
                        state_next = swmh_pkg::ST_FILL;
                    end else begin
                        state_next = swmh_pkg::ST_REPL_RD;
                    end
                end
            end
            swmh_pkg::ST_FILL: begin
                fill_next = fill_reg + CW'(1);
                if (fill_reg + CW'(1) < n_eff) begin
                    state_next = swmh_pkg::ST_IDLE;
                end else begin
                    oldest_next = '0;
                    mode_next   = swmh_pkg::MODE_BUILD;
                    root_next   = n_eff >> 1;
                    if ((n_eff >> 1) == '0) begin
                        state_next = swmh_pkg::ST_ROOT_RD;
                    end else begin
                        pos_next   = PW'((n_eff >> 1) - CW'(1));
                        root_next  = (n_eff >> 1) - CW'(1);
                        state_next = swmh_pkg::ST_SD_START;
                    end
                end
            end
            swmh_pkg::ST_REPL_RD: begin
                // slot_position read issued at oldest slot
                state_next = swmh_pkg::ST_REPL_WR;
            end
            swmh_pkg::ST_REPL_WR: begin
                // read the value being replaced
                pos_next    = sp_rdata;
                state_next  = swmh_pkg::ST_SD_RD_L;
                up_next     = 1'b1;  // marks replacement compare pending
                oldest_next = (CW'(oldest_reg) + CW'(1) >= n_eff) ? '0 : oldest_reg + PW'(1);
            end
            swmh_pkg::ST_SD_START: begin
                state_next = swmh_pkg::ST_SD_RD_L;
                up_next    = 1'b0;
            end
            swmh_pkg::ST_SD_RD_L: begin
                if (up_reg) begin
                    // previous value of replaced position arrives now
                    if (swmh_pkg::greater(key_reg, hv_rdata)) begin
                        mode_next = swmh_pkg::MODE_DOWN;
                    end else begin
                        mode_next = swmh_pkg::MODE_UP;
                    end
                    pv_next = key_reg;
                    ps_next = oldest_reg == '0 ? PW'(n_eff - CW'(1)) : oldest_reg - PW'(1);
                    up_next = 1'b0;
                    if (swmh_pkg::greater(key_reg, hv_rdata)) begin
                        // re-read the written position before sifting down
                        state_next = swmh_pkg::ST_SD_START;
                    end else begin
                        root_next  = CW'(pos_reg);
                        state_next = swmh_pkg::ST_SD_DONE;
                    end
                end else begin
                    pv_next    = hv_rdata;
                    ps_next    = hs_rdata;
                    state_next = swmh_pkg::ST_SD_RD_R;
                end
            end
            swmh_pkg::ST_SD_RD_R: begin
                lv_next    = hv_rdata;
                ls_next    = hs_rdata;
                state_next = swmh_pkg::ST_SD_CMP;
            end
            swmh_pkg::ST_SD_CMP: begin
                m_next  = pos_reg;
                mv_next = pv_reg;
                ms_next = ps_reg;
                if (l_ok && swmh_pkg::greater(pv_reg, lv_reg)) begin
                    m_next = PW'(lpos); mv_next = lv_reg; ms_next = ls_reg;
                end
                if (r_ok && swmh_pkg::greater(
                        (l_ok && swmh_pkg::greater(pv_reg, lv_reg)) ? lv_reg : pv_reg,
                        hv_rdata)) begin
                    m_next = PW'(rpos); mv_next = hv_rdata; ms_next = hs_rdata;
                end
                if (m_next == pos_reg) begin
                    state_next = swmh_pkg::ST_SD_DONE;
                end else begin
                    state_next = swmh_pkg::ST_SD_SW1;
                end
            end
            swmh_pkg::ST_SD_SW1: state_next = swmh_pkg::ST_SD_SW2;
            swmh_pkg::ST_SD_SW2: state_next = swmh_pkg::ST_SD_SW3;
            swmh_pkg::ST_SD_SW3: begin
                pos_next   = m_reg;
                state_next = swmh_pkg::ST_SD_RD_L;
                // parent value at new position is the moved value
            end
            swmh_pkg::ST_SD_DONE: begin
                unique case (mode_reg)
                    swmh_pkg::MODE_BUILD: begin
                        if (root_reg == '0) begin
                            state_next = swmh_pkg::ST_ROOT_RD;
                        end else begin
                            root_next  = root_reg - CW'(1);
                            pos_next   = PW'(root_reg - CW'(1));
                            state_next = swmh_pkg::ST_SD_START;
                        end
                    end
                    swmh_pkg::MODE_DOWN: state_next = swmh_pkg::ST_ROOT_RD;
                    default: begin
                        if (root_reg == '0) begin
                            state_next = swmh_pkg::ST_ROOT_RD;
                        end else begin
                            root_next  = (root_reg - CW'(1)) >> 1;
                            pos_next   = PW'((root_reg - CW'(1)) >> 1);
                            state_next = swmh_pkg::ST_SD_START;
                        end
                    end
                endcase
            end
            swmh_pkg::ST_ROOT_RD: state_next = swmh_pkg::ST_OUT;
            swmh_pkg::ST_OUT:     state_next = swmh_pkg::ST_IDLE;
            default:              state_next = swmh_pkg::ST_IDLE;
        endcase
    end

    // RAM control
    always_comb begin
        hv_we = 1'b0; hs_we = 1'b0; sp_we = 1'b0;
        hv_addr = pos_reg; hs_addr = pos_reg; sp_addr = oldest_reg;
        hv_wdata = key_reg; hs_wdata = pos_reg; sp_wdata = pos_reg;
        unique case (state_reg)
            swmh_pkg::ST_FILL: begin
                hv_we = 1'b1; hs_we = 1'b1; sp_we = 1'b1;
                hv_addr = PW'(fill_reg); hs_addr = PW'(fill_reg);
                sp_addr = PW'(fill_reg);
                hs_wdata = PW'(fill_reg); sp_wdata = PW'(fill_reg);
            end
            swmh_pkg::ST_REPL_RD: sp_addr = oldest_reg;
            swmh_pkg::ST_REPL_WR: begin
                // read old value, then overwrite with the new sample
                hv_addr = sp_rdata;
            end
            swmh_pkg::ST_SD_RD_L: begin
                if (up_reg) begin
                    // commit the replacement write
                    hv_we = 1'b1; hs_we = 1'b1; sp_we = 1'b1;
                    hv_addr = pos_reg; hs_addr = pos_reg;
                    hv_wdata = key_reg;
                    hs_wdata = oldest_reg == '0 ? PW'(n_eff - CW'(1)) : oldest_reg - PW'(1);
                    sp_addr  = hs_wdata;
                    sp_wdata = pos_reg;
                end else begin
                    hv_addr = PW'(lpos); hs_addr = PW'(lpos);
                end
            end
            swmh_pkg::ST_SD_START: begin
                hv_addr = pos_reg; hs_addr = pos_reg;
            end
            swmh_pkg::ST_SD_RD_R: begin
                hv_addr = PW'(rpos); hs_addr = PW'(rpos);
            end
            swmh_pkg::ST_SD_SW1: begin
                hv_we = 1'b1; hs_we = 1'b1; sp_we = 1'b1;
                hv_addr = pos_reg; hs_addr = pos_reg;
                hv_wdata = mv_reg; hs_wdata = ms_reg;
                sp_addr = ms_reg; sp_wdata = pos_reg;
            end
            swmh_pkg::ST_SD_SW2: begin
                hv_we = 1'b1; hs_we = 1'b1; sp_we = 1'b1;
                hv_addr = m_reg; hs_addr = m_reg;
                hv_wdata = pv_reg; hs_wdata = ps_reg;
                sp_addr = ps_reg; sp_wdata = m_reg;
            end
            swmh_pkg::ST_SD_SW3: begin
                hv_addr = m_reg; hs_addr = m_reg;
            end
            swmh_pkg::ST_ROOT_RD: begin
                hv_addr = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= swmh_pkg::ST_IDLE;
            mode_reg      <= swmh_pkg::MODE_BUILD;
            wsize_reg     <= swmh_pkg::WINDOW_RESET;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            up_reg     <= up_next;
            if (state_reg == swmh_pkg::ST_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                wsize_reg  <= cfg_wdata;
                fill_reg   <= '0;
                oldest_reg <= '0;
            end else begin
                fill_reg   <= fill_next;
                oldest_reg <= oldest_next;
            end
        end
    end

    // After a swap the sifted value sits at m_reg; SW3 re-reads it so the
    // next level starts from the RAM contents.
    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        root_reg <= root_next;
        pv_reg <= pv_next; lv_reg <= lv_next;
        ps_reg <= ps_next; ls_reg <= ls_next;
        m_reg <= m_next; mv_reg <= mv_next; ms_reg <= ms_next;
        if (state_reg == swmh_pkg::ST_OUT) begin
            out_reg <= hv_rdata;
        end
    end

endmodule

// File: rtl/core/swmh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmh_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module swmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/swmh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmh_checker: port-level checks
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module swmh_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [swmh_pkg::TDATA_W-1:0] m_axis_tdata
);

    // A waiting result holds its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No new item while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // An accepted item takes the block out of idle, so ready drops.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    // Nothing is shown after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result after reset");

endmodule

bind sliding_window_minimum_heap swmh_checker u_swmh_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: sliding_window_minimum_heap testbench
// Streams signed samples through the block under several window sizes,
// predicts each window minimum with a local indexed heap and checks every
// result in order, with random idling on both sides and long stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  SETTLE     = 40;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [swmh_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [swmh_pkg::TDATA_W-1:0]   s_axis_tdata = '0;   // [31:0] sample
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [swmh_pkg::TDATA_W-1:0]   m_axis_tdata;        // [31:0] window_min

    sliding_window_minimum_heap DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // local copy of the window heap
    logic signed [swmh_pkg::SAMPLE_WIDTH-1:0] win_value [swmh_pkg::MAX_WINDOW];
    int                             win_slot  [swmh_pkg::MAX_WINDOW];
    int                             slot_pos  [swmh_pkg::MAX_WINDOW];
    int                             next_oldest;
    int                             filled;
    logic [swmh_pkg::CFG_W-1:0]     window_reg;

    logic [swmh_pkg::SAMPLE_WIDTH-1:0] min_queue [$];
    int  errors = 0;
    bit  no_idle = 1'b0;
    int  hold_req = 0;
    longint cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sliding_window_minimum_heap test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic int window_len();
        if (window_reg == 0) return 1;
        if (window_reg > swmh_pkg::MAX_WINDOW) return swmh_pkg::MAX_WINDOW;
        return window_reg;
    endfunction

    task automatic heap_swap(input int a, input int b);
        logic signed [swmh_pkg::SAMPLE_WIDTH-1:0] v;
        int s;
        v = win_value[a]; s = win_slot[a];
        win_value[a] = win_value[b]; win_slot[a] = win_slot[b];
        win_value[b] = v; win_slot[b] = s;
        slot_pos[win_slot[a]] = a;
        slot_pos[win_slot[b]] = b;
    endtask

    task automatic heap_sink(input int pos, input int n);
        int l, r, m;
        forever begin
            l = 2 * pos + 1;
            r = 2 * pos + 2;
            m = pos;
            if (l < n && win_value[m] > win_value[l]) m = l;
            if (r < n && win_value[m] > win_value[r]) m = r;
            if (m == pos) break;
            heap_swap(m, pos);
            pos = m;
        end
    endtask

    // Push one sample; queue the new minimum when the window is full.
    task automatic window_push(input logic signed [swmh_pkg::SAMPLE_WIDTH-1:0] s);
        int n, slot, pos, r;
        logic signed [swmh_pkg::SAMPLE_WIDTH-1:0] prev;
        n = window_len();
        if (filled < n) begin
            win_value[filled] = s;
            win_slot[filled]  = filled;
            slot_pos[filled]  = filled;
            filled++;
            if (filled < n) return;
            for (r = n / 2 - 1; r >= 0; r--) heap_sink(r, n);
            next_oldest = 0;
        end else begin
            slot = next_oldest % n;
            pos  = slot_pos[slot] % n;
            prev = win_value[pos];
            win_value[pos] = s;
            win_slot[pos]  = slot;
            slot_pos[slot] = pos;
            next_oldest = (slot + 1) % n;
            if (s > prev) begin
                heap_sink(pos, n);
            end else begin
                // re-heapify every ancestor up to the root
                forever begin
                    pos = (pos == 0) ? 0 : (pos - 1) / 2;
                    heap_sink(pos, n);
                    if (pos == 0) break;
                end
            end
        end
        min_queue.push_back(win_value[0]);
    endtask

    task automatic report(input string what, input logic [swmh_pkg::SAMPLE_WIDTH-1:0] got,
                          input logic [swmh_pkg::SAMPLE_WIDTH-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycles);
        errors++;
    endtask

    // receiver: random short gaps, the odd long one, and requested hold-offs
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
                if ($urandom_range(0, 99) == 0) hold_left = $urandom_range(20, 60);
            end
        end
    end

    // check each result against the oldest expected minimum
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                if (min_queue.size() == 0)
                    report("unexpected result",
                           m_axis_tdata[swmh_pkg::SAMPLE_WIDTH-1:0], '0);
                else if (m_axis_tdata[swmh_pkg::SAMPLE_WIDTH-1:0] != min_queue[0])
                    report("window_min", m_axis_tdata[swmh_pkg::SAMPLE_WIDTH-1:0],
                           min_queue.pop_front());
                else
                    void'(min_queue.pop_front());
            end
        end
    end

    task automatic send_item(input logic [swmh_pkg::SAMPLE_WIDTH-1:0] v);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= swmh_pkg::TDATA_W'(v);
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        window_push(v);
    endtask

    // drop valid and let the block settle with nothing outstanding
    task automatic drain();
        @(posedge aclk);
        s_axis_tvalid <= 1'b0;
        wait (min_queue.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_window(input logic [swmh_pkg::CFG_W-1:0] w);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        window_reg = w;
        filled = 0;
        next_oldest = 0;
    endtask

    function automatic logic [swmh_pkg::SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 15) - 8;   // frequent ties
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_window();
        // reset size is 16: first result on the sixteenth item
        for (int i = 0; i < 20; i++) send_item(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF - i);
    endtask

    task automatic test_extremes();
        set_window(1);
        send_item(32'h8000_0000);
        send_item(32'h7FFF_FFFF);
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        set_window(2);
        send_item(5);
        send_item(5);
        send_item(5);   // equal replacement
        send_item(32'hFFFF_FFFF);
        send_item(32'h7FFF_FFFF);
        send_item(32'h8000_0000);
    endtask

    task automatic test_size_limits();
        set_window(0);   // acts as 1
        send_item(-3);
        send_item(7);
        set_window(127); // saturates to the largest window
        for (int i = 0; i < 70; i++) send_item(rand_sample());
    endtask

    task automatic test_random();
        logic [swmh_pkg::CFG_W-1:0] sizes [8] = '{3, 64, 2, 16, 5, 1, 33, 8};
        for (int k = 0; k < 8; k++) begin
            set_window(sizes[k]);
            no_idle = (k == 3);
            for (int i = 0; i < 120; i++) send_item(rand_sample());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_window(4);
        hold_req = 300;
        for (int i = 0; i < 60; i++) send_item(rand_sample());
    endtask

    initial begin
        window_reg  = swmh_pkg::WINDOW_RESET;
        filled      = 0;
        next_oldest = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_window();
        test_extremes();
        test_size_limits();
        test_random();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("sliding_window_minimum_heap test passed");
        else
            $display("sliding_window_minimum_heap test failed");
        $finish;
    end

endmodule

// File: sliding_window_minimum_heap.f
rtl/core/swmh_pkg.sv
rtl/core/swmh_ram.sv
rtl/core/sliding_window_minimum_heap.sv
rtl/core/swmh_checker.sv
tb/sv/tb_top.sv
